// ----- hdl/dxt_block_decoder_macros.svh -----
// Assertion macros used by the decoder back end.
// Needs nothing else; take it in with an include inside the module that asserts.
`ifndef DXT_BLOCK_DECODER_MACROS_SVH
`define DXT_BLOCK_DECODER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define DBD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define DBD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dbd_pkg.sv -----
// Types, format codes and constant dividers for the DXT block decoder.
// No dependencies; every decoder module imports it.
`timescale 1ns / 1ps

package dbd_pkg;

  // Block format codes held in the format register
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // Configuration register indexes
  localparam logic REG_BLOCK_FORMAT = 1'b0;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

  // One compressed block
  typedef struct packed {
    logic [63:0] alpha_word;
    logic [63:0] color_word;
  } dbd_in_t;

  // One decoded pixel
  typedef struct packed {
    logic [31:0] pixel_color;
    logic [3:0]  pixel_index;
    logic        last_pixel;
  } dbd_pix_t;

  // A classified block: palette and alpha table ready, indices still packed
  typedef struct packed {
    logic [1:0]       fmt;
    logic [3:0][31:0] pal;
    logic [7:0][7:0]  atab;
    logic [31:0]      cidx;
    logic [63:0]      aword;
  } dbd_blk_t;

  // Divide by 3 for values up to 765: multiply by 683 / 2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // Divide by 7 for values up to 1785: multiply by 2341 / 16384
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // Divide by 5 for values up to 1275: multiply by 3277 / 16384
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

endpackage

// ----- hdl/dxt_block_decoder.sv -----
// DXT1/DXT3/DXT5 block decoder: 16 RGBA8888 pixels per 4x4 compressed block.
// A block passes the input stage and the queue, then its 16 pixels leave the
// single-pixel output register one per cycle while out_stall is low.
// Two blocks can wait in the queue, so input transfers continue while pixels drain.
// Synchronous reset clears the format register to DXT1 and empties all stages.
`timescale 1ns / 1ps

module dxt_block_decoder import dbd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  dbd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output dbd_pix_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] block_format;
  logic       push;
  dbd_blk_t   push_data;
  logic       q_full;
  logic       pop;
  dbd_blk_t   head;
  logic       head_valid;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLOCK_FORMAT) ? {30'd0, block_format} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_DXT1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BLOCK_FORMAT) begin
      block_format <= pwdata[1:0];
    end
  end

  dbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .fmt       (block_format),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  dbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  dbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- hdl/dbd_front.sv -----
// Front end: takes compressed blocks, builds colour palette and alpha table.
// Depends on dbd_pkg; feeds dbd_queue.
`timescale 1ns / 1ps

module dbd_front import dbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic [1:0] fmt,
  input  logic     in_valid,
  output logic     in_stall,
  input  dbd_in_t  in_data,
  output logic     push,
  output dbd_blk_t push_data,
  input  logic     q_full
);

  logic       s_valid;
  dbd_in_t    s_word;
  logic [1:0] s_fmt;

  // Expand an RGB565 colour to RGB888 by bit replication
  function automatic logic [2:0][7:0] expand565(input logic [15:0] c);
    logic [2:0][7:0] e;
    e[0] = {c[15:11], c[15:13]};
    e[1] = {c[10:5], c[10:9]};
    e[2] = {c[4:0], c[4:2]};
    return e;
  endfunction

  function automatic logic [3:0][31:0] build_pal(input logic [31:0] ends, input logic dxt1);
    logic [3:0][31:0] p;
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic [15:0]      c0;
    logic [15:0]      c1;
    logic [31:0]      a;
    logic [2:0][7:0]  m2;
    logic [2:0][7:0]  m3;
    logic [2:0][7:0]  avg;
    logic [8:0]       s;
    c0 = ends[15:0];
    c1 = ends[31:16];
    a  = dxt1 ? ALPHA_OPAQUE : 32'd0;
    e0 = expand565(c0);
    e1 = expand565(c1);
    for (int ch = 0; ch < 3; ch++) begin
      m2[ch]  = div3({1'b0, e0[ch], 1'b0} + 10'(e1[ch]));
      m3[ch]  = div3(10'(e0[ch]) + {1'b0, e1[ch], 1'b0});
      s       = 9'(e0[ch]) + 9'(e1[ch]) + 9'd1;
      avg[ch] = s[8:1];
    end
    p[0] = a;
    p[1] = a;
    p[2] = a;
    p[3] = 32'd0;
    if (c0 != 16'd0 || c1 != 16'd0) begin
      p[0] = {8'd0, e0[2], e0[1], e0[0]} | a;
      p[1] = {8'd0, e1[2], e1[1], e1[0]} | a;
      if (!dxt1 || c0 > c1) begin
        p[2] = {8'd0, m2[2], m2[1], m2[0]} | a;
        p[3] = {8'd0, m3[2], m3[1], m3[0]} | a;
      end else begin
        p[2] = {8'd0, avg[2], avg[1], avg[0]} | a;
      end
    end
    return p;
  endfunction

  function automatic logic [7:0][7:0] build_atab(input logic [15:0] ends);
    logic [7:0][7:0] t;
    logic [7:0]      a0;
    logic [7:0]      a1;
    logic [10:0]     s;
    a0 = ends[7:0];
    a1 = ends[15:8];
    t[0] = a0;
    t[1] = a1;
    if (a0 > a1) begin
      for (int i = 2; i < 8; i++) begin
        s    = 11'(a0) * 11'(8 - i) + 11'(a1) * 11'(i - 1);
        t[i] = div7(s);
      end
    end else begin
      for (int i = 2; i < 6; i++) begin
        s    = 11'(a0) * 11'(6 - i) + 11'(a1) * 11'(i - 1);
        t[i] = div5(s);
      end
      t[6] = 8'd0;
      t[7] = 8'd255;
    end
    return t;
  endfunction

  // Hold the input stage while the queue is full
  assign in_stall = s_valid && q_full;
  assign push     = s_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!s_valid || !q_full) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_word <= in_data;
      s_fmt  <= fmt;
    end
  end

  // Classify the staged block
  always_comb begin
    push_data.fmt   = s_fmt;
    push_data.pal   = build_pal(s_word.color_word[31:0], s_fmt == FMT_DXT1);
    push_data.atab  = build_atab(s_word.alpha_word[15:0]);
    push_data.cidx  = s_word.color_word[63:32];
    push_data.aword = s_word.alpha_word;
  end

endmodule

// ----- hdl/dbd_queue.sv -----
// Short block queue between the front end and the pixel back end.
// Depends on dbd_pkg for the block type.
`timescale 1ns / 1ps

module dbd_queue import dbd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  dbd_blk_t push_data,
  output logic     full,
  input  logic     pop,
  output dbd_blk_t head,
  output logic     head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dbd_blk_t   entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/dbd_back.sv -----
// Back end: walks the queued block and emits one pixel per transfer.
// Depends on dbd_pkg and the decoder assertion macros.
`timescale 1ns / 1ps
`include "dxt_block_decoder_macros.svh"

module dbd_back import dbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dbd_blk_t head,
  input  logic     head_valid,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output dbd_pix_t out_data
);

  logic [3:0]  cnt;
  logic        load;
  logic [1:0]  ci;
  logic [2:0]  ai;
  logic [3:0]  a4;
  logic [7:0]  alpha;
  logic [31:0] px;

  // Load the output register when a block is queued and the register is free or being taken
  assign load = head_valid && (!out_valid || !out_stall);
  assign pop  = load && (cnt == 4'd15);

  // Pick the pixel at the current position
  always_comb begin
    ci    = head.cidx[2*cnt +: 2];
    ai    = head.aword[16 + 3*cnt +: 3];
    a4    = head.aword[4*cnt +: 4];
    alpha = head.atab[ai];
    unique case (head.fmt)
      FMT_DXT1: px = head.pal[ci];
      FMT_DXT3: px = {a4, a4, head.pal[ci][23:0]};
      default:  px = {alpha, head.pal[ci][23:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= 4'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        cnt       <= cnt + 4'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.pixel_color <= px;
      out_data.pixel_index <= cnt;
      out_data.last_pixel  <= (cnt == 4'd15);
    end
  end

  `DBD_ASSERT_IMPL(a_last_at_end, clk, rst, out_valid && out_data.last_pixel, out_data.pixel_index == 4'd15, "last flag away from position 15")
  `DBD_ASSERT_NEXT(a_index_steps, clk, rst, out_valid && !out_stall && !out_data.last_pixel && head_valid, out_valid && out_data.pixel_index == 4'($past(out_data.pixel_index) + 4'd1), "pixel position skipped")
  `DBD_ASSERT_IMPL(a_rise_needs_block, clk, rst, $rose(out_valid), $past(head_valid), "pixel emitted without a queued block")

endmodule
